// File: hw/rtl/gf_pkg.sv
package gf_pkg;

    // Field x^8 + x^4 + x^3 + x^2 + 1, generator 2
    localparam logic [8:0] FieldPoly  = 9'h11D;
    localparam int         GroupOrder = 255;

    // Operation codes carried in the command field
    typedef enum logic [1:0] {
        CmdMul = 2'd0,
        CmdDiv = 2'd1,
        CmdInv = 2'd2,
        CmdPow = 2'd3
    } gf_cmd_t;

    typedef logic [255:0][7:0] gf_table_t;

    // Antilog table: entry i holds 2^i; entry 255 wraps back to 1
    function automatic gf_table_t build_antilog();
        gf_table_t  t;
        logic [8:0] x;
        x = 9'd1;
        for (int i = 0; i < 256; i++)
        begin
            t[i] = x[7:0];
            x = {x[7:0], 1'b0};
            if (x[8])
            begin
                x = x ^ FieldPoly;
            end
        end
        return t;
    endfunction

    // Log table: inverse of the antilog over the 255 nonzero elements
    function automatic gf_table_t build_log();
        gf_table_t t;
        gf_table_t alog;
        t    = '0;
        alog = build_antilog();
        for (int i = 0; i < GroupOrder; i++)
        begin
            t[alog[i]] = 8'(i);
        end
        return t;
    endfunction

    // Residue mod 255 of a 16-bit value: fold bytes with end-around carry
    function automatic logic [7:0] mod255(input logic [15:0] x);
        logic [8:0] s;
        logic [8:0] t;
        s = {1'b0, x[15:8]} + {1'b0, x[7:0]};
        t = {1'b0, s[7:0]} + {8'd0, s[8]};
        return (t[7:0] == 8'hFF) ? 8'd0 : t[7:0];
    endfunction

endpackage

// File: hw/rtl/gf_req_if.sv
interface gf_req_if;
    logic                  valid;
    logic                  ready;
    gf_pkg::gf_cmd_t       command;
    logic [7:0]            operand_a;
    logic [7:0]            operand_b;
    logic signed [15:0]    exponent;

    modport source (output valid, command, operand_a, operand_b, exponent, input ready);
    modport sink   (input valid, command, operand_a, operand_b, exponent, output ready);
endinterface

// File: hw/rtl/gf_rsp_if.sv
interface gf_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] result;
    logic       zero_error;

    modport source (output valid, result, zero_error, input ready);
    modport sink   (input valid, result, zero_error, output ready);
endinterface

// File: hw/rtl/gf256_arithmetic_unit.sv
// GF(2^8) arithmetic unit over x^8+x^4+x^3+x^2+1 (generator 2): multiply, divide,
// inverse and signed-exponent power. Each word passes through an input register and a
// result register, and one word is taken every cycle while the response side keeps up;
// the rate is set by a single pass through the log ROM, one 8x8 multiply for the power
// exponent, a mod-255 fold and the antilog ROM. A zero factor, a zero dividend or a
// zero base with a nonzero exponent gives 0, any base to the power 0 gives 1, division
// by zero returns the dividend and the inverse of zero returns 1, both with zero_error set.
module gf256_arithmetic_unit
(
    input  logic     clk,
    input  logic     rst_n,
    gf_req_if.sink   req,
    gf_rsp_if.source rsp
);

    localparam gf_pkg::gf_table_t LogRom     = gf_pkg::build_log();
    localparam gf_pkg::gf_table_t AntilogRom = gf_pkg::build_antilog();

    // Input stage
    logic                s1_valid_reg;
    gf_pkg::gf_cmd_t     cmd_reg;
    logic [7:0]          a_reg;
    logic [7:0]          b_reg;
    logic signed [15:0]  exp_reg;

    // Result stage
    logic                out_valid_reg;
    logic [7:0]          result_reg;
    logic                zero_error_reg;
    logic [7:0]          result_next;
    logic                zero_error_next;

    logic                s1_advance;
    logic                accept;

    // Log-domain working values
    logic [7:0]          la;
    logic [7:0]          lb;
    logic                a_zero;
    logic                b_zero;
    logic [7:0]          exp_res;
    logic [7:0]          pm;
    logic [15:0]         pow_prod;
    logic [7:0]          pow_log;
    logic [7:0]          log_idx;
    logic [7:0]          alog_val;

    // Handshake: result register empties or drains, input stage follows
    assign s1_advance = !out_valid_reg || rsp.ready;
    assign req.ready  = !s1_valid_reg || s1_advance;
    assign accept     = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                s1_valid_reg <= req.valid;
            end
            if (s1_advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= req.command;
            a_reg   <= req.operand_a;
            b_reg   <= req.operand_b;
            exp_reg <= req.exponent;
        end
        if (s1_advance && s1_valid_reg)
        begin
            result_reg     <= result_next;
            zero_error_reg <= zero_error_next;
        end
    end

    assign la     = LogRom[a_reg];
    assign lb     = LogRom[b_reg];
    assign a_zero = (a_reg == 8'd0);
    assign b_zero = (b_reg == 8'd0);

    // Exponent mod 255; 2^16 = 1 mod 255, so a negative value reduces as (raw - 1)
    assign exp_res  = gf_pkg::mod255(exp_reg);
    assign pm       = !exp_reg[15] ? exp_res
                    : (exp_res == 8'd0) ? 8'd254 : (exp_res - 8'd1);
    assign pow_prod = {8'd0, la} * {8'd0, pm};
    assign pow_log  = gf_pkg::mod255(pow_prod);

    // Log of the result for each operation
    always_comb
    begin
        unique case (cmd_reg)
            gf_pkg::CmdMul: log_idx = gf_pkg::mod255(16'(la) + 16'(lb));
            gf_pkg::CmdDiv: log_idx = gf_pkg::mod255(16'(la) + 16'(8'd255 - lb));
            gf_pkg::CmdInv: log_idx = gf_pkg::mod255(16'(8'd255 - la));
            gf_pkg::CmdPow: log_idx = pow_log;
            default:        log_idx = 8'd0;
        endcase
    end

    assign alog_val = AntilogRom[log_idx];

    // Zero operands and error cases
    always_comb
    begin
        result_next     = alog_val;
        zero_error_next = 1'b0;
        unique case (cmd_reg)
            gf_pkg::CmdMul:
            begin
                if (a_zero || b_zero)
                begin
                    result_next = 8'd0;
                end
            end
            gf_pkg::CmdDiv:
            begin
                if (b_zero)
                begin
                    result_next     = a_reg;
                    zero_error_next = 1'b1;
                end
                else if (a_zero)
                begin
                    result_next = 8'd0;
                end
            end
            gf_pkg::CmdInv:
            begin
                if (a_zero)
                begin
                    result_next     = 8'd1;
                    zero_error_next = 1'b1;
                end
            end
            gf_pkg::CmdPow:
            begin
                if (exp_reg == 16'sd0)
                begin
                    result_next = 8'd1;
                end
                else if (a_zero)
                begin
                    result_next = 8'd0;
                end
            end
            default:
            begin
                result_next = alog_val;
            end
        endcase
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.result     = result_reg;
    assign rsp.zero_error = zero_error_reg;

endmodule
